### design/rhh_pkg.sv
//------------------------------------------------------------------------------
// rhh_pkg
// Shared types and constants for the Robin Hood hash table unit.
//------------------------------------------------------------------------------
package rhh_pkg;

	localparam int unsigned SLOTS_DEF       = 64;
	localparam int unsigned KEY_BYTES_DEF   = 8;
	localparam int unsigned VALUE_BYTES_DEF = 8;

	localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME  = 32'd16777619;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY_KEY = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_FRD,
		S_FCHK,
		S_PRD,
		S_PCHK,
		S_DRD,
		S_DCHK,
		S_DONE
	} state_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++)
			if (4'(i) < n) m[i*8 +: 8] = 8'hFF;
		return m;
	endfunction

endpackage

### design/rhh_if.sv
//------------------------------------------------------------------------------
// rhh_req_if / rhh_rsp_if
// Valid/ready channels for request and response words.
//------------------------------------------------------------------------------
interface rhh_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [63:0] key;
	logic [3:0]  key_len;
	logic [63:0] value;
	logic [3:0]  val_len;
	modport source (output valid, operation, key, key_len, value, val_len, input ready);
	modport sink   (input valid, operation, key, key_len, value, val_len, output ready);
endinterface

interface rhh_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] found_value;
	logic [3:0]  found_value_len;
	logic [6:0]  entries;
	modport source (output valid, status, found_value, found_value_len, entries, input ready);
	modport sink   (input valid, status, found_value, found_value_len, entries, output ready);
endinterface

### design/rhh_hash.sv
//------------------------------------------------------------------------------
// rhh_hash
// FNV-1a over up to eight key bytes, one byte and one multiply a cycle.
//------------------------------------------------------------------------------
module rhh_hash import rhh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	input  logic [3:0]  key_len,
	output logic        done,
	output logic [31:0] hash
);
	logic [31:0] h_q;
	logic [3:0]  i_q;
	logic        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			if (i_q == key_len) busy_q <= 1'b0;
			else i_q <= i_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) h_q <= FNV_OFFSET;
		else if (busy_q && i_q != key_len)
			h_q <= (h_q ^ {24'd0, key[i_q[2:0]*8 +: 8]}) * FNV_PRIME;
	end

	assign done = busy_q && (i_q == key_len);
	assign hash = h_q;
endmodule

### design/robin_hood_hash_table_unit.sv
//------------------------------------------------------------------------------
// robin_hood_hash_table_unit
// Open-addressed Robin Hood hash table, backward-shift delete, FNV-1a hash.
//------------------------------------------------------------------------------
// channel | dir | words
// req     | in  | operation, key, key_len, value, val_len
// rsp     | out | status, found_value, found_value_len, entries
//
// One word at a time in the datapath; the response sits in its own register.
// The hash runs first; then each slot visited by the search, placement or
// shift walk takes a registered memory read, then a compare/write.
// Reserved or empty-key words skip the hash and the walk; the worst case
// walks all SLOTS.
// Reset clears the used bits and count at once; no clearing pass.
// An untaken response holds the next word in its last state until it goes.
//------------------------------------------------------------------------------
module robin_hood_hash_table_unit import rhh_pkg::*; #(
	parameter int unsigned SLOTS       = SLOTS_DEF,
	parameter int unsigned KEY_BYTES   = KEY_BYTES_DEF,
	parameter int unsigned VALUE_BYTES = VALUE_BYTES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	rhh_req_if.sink  req,
	rhh_rsp_if.source rsp
);
	localparam int unsigned IW = $clog2(SLOTS);
	localparam int unsigned CW = IW + 1;
	localparam int unsigned KW = KEY_BYTES * 8;
	localparam int unsigned VW = VALUE_BYTES * 8;

	typedef struct packed {
		logic [IW-1:0] psl;
		logic [31:0]   hash;
		logic [KW-1:0] key;
		logic [3:0]    klen;
		logic [VW-1:0] val;
		logic [3:0]    vlen;
	} ent_t;

	ent_t          mem [SLOTS];
	logic [SLOTS-1:0] used_q, used_d;
	ent_t          rd_q;
	logic          rd_used_q;

	state_t        st_q, st_d;
	op_t           op_q;
	ent_t          cur_q;
	logic [IW-1:0] idx_q, hole_q;
	logic [CW-1:0] step_q, cnt_q, cnt_d;
	logic [1:0]    status_q;
	logic [VW-1:0] fv_q;
	logic [3:0]    fvl_q;
	logic          rsp_valid_q;
	logic [1:0]    rsp_status_q;
	logic [VW-1:0] rsp_fv_q;
	logic [3:0]    rsp_fvl_q;
	logic [6:0]    rsp_ent_q;

	logic          hstart, hdone;
	logic [31:0]   hval;
	logic [3:0]    kl_c, vl_c;
	logic [63:0]   key_m, val_m;

	always_comb begin
		kl_c = (req.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req.key_len;
		vl_c = (req.val_len > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES) : req.val_len;
		key_m = req.key & byte_mask(kl_c);
		val_m = req.value & byte_mask(vl_c);
	end

	wire acc = req.valid && req.ready;
	wire rsp_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (st_q == S_IDLE);
	assign hstart = acc && req.operation != OP_RSVD && kl_c != 4'd0;

	rhh_hash u_hash (.clk, .arst_n, .start(hstart), .key(64'(cur_q.key)),
		.key_len(cur_q.klen), .done(hdone), .hash(hval));

	wire match = rd_used_q && rd_q.hash == cur_q.hash && rd_q.klen == cur_q.klen
		&& rd_q.key == cur_q.key;
	wire stop_find = !rd_used_q || (step_q[IW-1:0] > rd_q.psl && step_q < CW'(SLOTS))
		|| step_q == CW'(SLOTS);
	wire full = cnt_q == CW'(SLOTS);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (acc) st_d = hstart ? S_HASH : S_DONE;
			S_HASH: if (hdone) st_d = S_FRD;
			S_FRD:  st_d = S_FCHK;
			S_FCHK: begin
				if (stop_find)
					st_d = (op_q == OP_INSERT && !full) ? S_PRD : S_DONE;
				else if (match)
					st_d = (op_q == OP_DELETE) ? S_DRD : S_DONE;
				else st_d = S_FRD;
			end
			S_PRD:  st_d = S_PCHK;
			S_PCHK: st_d = (!rd_used_q || step_q == CW'(SLOTS - 1)) ? S_DONE : S_PRD;
			S_DRD:  st_d = S_DCHK;
			S_DCHK: st_d = (!rd_used_q || rd_q.psl == '0 || step_q == CW'(SLOTS - 1))
				? S_DONE : S_DRD;
			S_DONE: st_d = rsp_free ? S_IDLE : S_DONE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		used_d = used_q;
		cnt_d  = cnt_q;
		if (st_q == S_PCHK && !rd_used_q) begin
			used_d[idx_q] = 1'b1;
			cnt_d = cnt_q + 1'b1;
		end
		if (st_q == S_FCHK && st_d == S_DRD) begin
			used_d[idx_q] = 1'b0;
			cnt_d = cnt_q - 1'b1;
		end
		if (st_q == S_DCHK && rd_used_q && rd_q.psl != '0) begin
			used_d[hole_q] = 1'b1;
			used_d[idx_q]  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_q      <= mem[idx_q];
		rd_used_q <= used_q[idx_q];
		if (st_q == S_PCHK) begin
			if (!rd_used_q || cur_q.psl > rd_q.psl) mem[idx_q] <= cur_q;
		end else if (st_q == S_DCHK && rd_used_q && rd_q.psl != '0) begin
			mem[hole_q] <= '{psl: rd_q.psl - 1'b1, hash: rd_q.hash, key: rd_q.key,
				klen: rd_q.klen, val: rd_q.val, vlen: rd_q.vlen};
		end else if (st_q == S_FCHK && match && op_q == OP_INSERT && step_q != CW'(SLOTS)
				&& step_q[IW-1:0] <= rd_q.psl) begin
			mem[idx_q] <= '{psl: rd_q.psl, hash: rd_q.hash, key: rd_q.key, klen: rd_q.klen,
				val: cur_q.val, vlen: cur_q.vlen};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			used_q       <= '0;
			cnt_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= '0;
			rsp_fv_q     <= '0;
			rsp_fvl_q    <= '0;
			rsp_ent_q    <= '0;
		end else begin
			st_q   <= st_d;
			used_q <= used_d;
			cnt_q  <= cnt_d;
			if (st_q == S_DONE && rsp_free) rsp_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
			if (st_q == S_DONE && rsp_free) begin
				rsp_status_q <= status_q;
				rsp_fv_q     <= fv_q;
				rsp_fvl_q    <= fvl_q;
				rsp_ent_q    <= 7'(cnt_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (acc) begin
				op_q     <= op_t'(req.operation);
				cur_q    <= '{psl: '0, hash: '0, key: key_m[KW-1:0], klen: kl_c,
					val: val_m[VW-1:0], vlen: vl_c};
				fv_q     <= '0;
				fvl_q    <= '0;
				step_q   <= '0;
				status_q <= (req.operation == OP_RSVD) ? ST_NOT_FOUND :
					(kl_c == 4'd0) ? ST_EMPTY_KEY : ST_OK;
			end
			S_HASH: begin
				cur_q.hash <= hval;
				idx_q      <= hval[IW-1:0];
			end
			S_FCHK: begin
				if (st_d == S_FRD) begin
					idx_q  <= idx_q + 1'b1;
					step_q <= step_q + 1'b1;
				end else if (st_d == S_PRD) begin
					idx_q  <= cur_q.hash[IW-1:0];
					step_q <= '0;
				end else if (st_d == S_DRD) begin
					hole_q <= idx_q;
					idx_q  <= idx_q + 1'b1;
					step_q <= '0;
				end else if (match && step_q != CW'(SLOTS) && step_q[IW-1:0] <= rd_q.psl
						&& rd_used_q) begin
					if (op_q == OP_LOOKUP) begin
						fv_q  <= rd_q.val;
						fvl_q <= rd_q.vlen;
					end
				end else begin
					status_q <= (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
				end
			end
			S_PCHK: begin
				if (rd_used_q && cur_q.psl > rd_q.psl)
					cur_q <= '{psl: rd_q.psl + 1'b1, hash: rd_q.hash, key: rd_q.key,
						klen: rd_q.klen, val: rd_q.val, vlen: rd_q.vlen};
				else cur_q.psl <= cur_q.psl + 1'b1;
				idx_q  <= idx_q + 1'b1;
				step_q <= step_q + 1'b1;
			end
			S_DCHK: begin
				hole_q <= idx_q;
				idx_q  <= idx_q + 1'b1;
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.found_value     = 64'(rsp_fv_q);
	assign rsp.found_value_len = rsp_fvl_q;
	assign rsp.entries         = rsp_ent_q;
endmodule

### design/rhh_checker.sv
//------------------------------------------------------------------------------
// rhh_checker
// Port-level checks on the hash table unit.
//------------------------------------------------------------------------------
module rhh_checker import rhh_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input logic [6:0] rsp_entries
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("response dropped while stalled");
	a_rsp_entries_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_entries))
		else $error("entry count moved while stalled");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready after accept");
	a_entries_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> rsp_entries - $past(rsp_entries, 1) <= 7'd1
			|| $past(rsp_entries, 1) - rsp_entries <= 7'd1)
		else $error("entry count jumped");
endmodule

bind robin_hood_hash_table_unit rhh_checker u_rhh_checker (
	.clk, .arst_n,
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
	.rsp_entries(rsp.entries)
);
